// File: design/fbt_pkg.sv
// Shared types and codes for the free block table fit core.
// No dependencies; used by fbt_cell and free_block_table_fit_core.
package fbt_pkg;

   localparam int POS_W = 10;

   localparam logic [1:0] CMD_INS_SIZE = 2'd0;
   localparam logic [1:0] CMD_INS_ADDR = 2'd1;
   localparam logic [1:0] CMD_BEST_FIT = 2'd2;
   localparam logic [1:0] CMD_SMALL_FIT = 2'd3;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   localparam logic [0:0] REG_MARGIN = 1'b0;
   localparam logic [0:0] REG_CEILING = 1'b1;

   // Search token that walks down the cell row.
   typedef struct packed {
      logic              have;
      logic              done;
      logic [31:0]       best;
      logic [POS_W-1:0]  pos;
      logic [31:0]       addr;
      logic [31:0]       size;
   } token_type;

   // Broadcast controls from the sequencer to every cell.
   typedef struct packed {
      logic [1:0]        cmd;
      logic [31:0]       addr;
      logic [31:0]       bsize;
      logic [31:0]       req;
      logic [16:0]       margin;
      logic              do_insert;
      logic              do_remove;
      logic [POS_W-1:0]  pos;
   } ctrl_type;

endpackage

// File: design/fbt_cell.sv
// One table entry with its stage of the search token pipeline.
// Depends on fbt_pkg.
module fbt_cell #(
   parameter int IDX = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  fbt_pkg::ctrl_type  ctrl,
   input  fbt_pkg::token_type tok_prev,
   output fbt_pkg::token_type tok_out,
   input  logic               left_valid,
   input  logic [31:0]        left_addr,
   input  logic [31:0]        left_size,
   input  logic               right_valid,
   input  logic [31:0]        right_addr,
   input  logic [31:0]        right_size,
   output logic               valid,
   output logic [31:0]        addr,
   output logic [31:0]        size
);

   localparam logic [fbt_pkg::POS_W-1:0] MY_POS = fbt_pkg::POS_W'(IDX);

   logic               valid_ff, valid_in;
   logic [31:0]        addr_ff, addr_in, size_ff, size_in;
   fbt_pkg::token_type tok_ff, tok_in;
   logic [31:0]        surplus;

   assign surplus = size_ff - ctrl.req;

   always_comb begin
      tok_in = tok_prev;
      if (valid_ff && !tok_prev.done) begin
         unique case (ctrl.cmd)
            fbt_pkg::CMD_INS_SIZE: begin
               if (size_ff >= ctrl.bsize) begin
                  tok_in.have = 1'b1;
                  tok_in.done = 1'b1;
                  tok_in.pos = MY_POS;
               end
            end
            fbt_pkg::CMD_INS_ADDR: begin
               if (addr_ff > ctrl.addr) begin
                  tok_in.have = 1'b1;
                  tok_in.done = 1'b1;
                  tok_in.pos = MY_POS;
               end
            end
            fbt_pkg::CMD_BEST_FIT: begin
               if (size_ff >= ctrl.req) begin
                  if (surplus < {15'd0, ctrl.margin}) begin
                     tok_in.have = 1'b1;
                     tok_in.done = 1'b1;
                     tok_in.pos = MY_POS;
                     tok_in.addr = addr_ff;
                     tok_in.size = size_ff;
                  end else if (size_ff > tok_prev.best) begin
                     tok_in.have = 1'b1;
                     tok_in.best = size_ff;
                     tok_in.pos = MY_POS;
                     tok_in.addr = addr_ff;
                     tok_in.size = size_ff;
                  end
               end
            end
            default: begin
               if (size_ff >= ctrl.req && size_ff < tok_prev.best) begin
                  tok_in.have = 1'b1;
                  tok_in.best = size_ff;
                  tok_in.pos = MY_POS;
                  tok_in.addr = addr_ff;
                  tok_in.size = size_ff;
                  tok_in.done = (size_ff == ctrl.req);
               end
            end
         endcase
      end
   end

   // Insert opens a gap by pulling from the left; removal closes it from the right.
   always_comb begin
      valid_in = valid_ff;
      addr_in = addr_ff;
      size_in = size_ff;
      if (ctrl.do_insert) begin
         if (MY_POS > ctrl.pos) begin
            valid_in = left_valid;
            addr_in = left_addr;
            size_in = left_size;
         end else if (MY_POS == ctrl.pos) begin
            valid_in = 1'b1;
            addr_in = ctrl.addr;
            size_in = ctrl.bsize;
         end
      end else if (ctrl.do_remove) begin
         if (MY_POS >= ctrl.pos) begin
            valid_in = right_valid;
            addr_in = right_addr;
            size_in = right_size;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      addr_ff <= addr_in;
      size_ff <= size_in;
      tok_ff <= tok_in;
   end

   assign tok_out = tok_ff;
   assign valid = valid_ff;
   assign addr = addr_ff;
   assign size = size_ff;

endmodule

// File: design/free_block_table_fit_core.sv
// An item passes through the idle, scan, apply and output states in turn. The idle
// state accepts the command. The scan state then lets a search token pass one
// cell per cycle down the row of entries and settle at its end. The apply state
// shifts the row for the insert or removal, and the output state presents the
// result beat. One item is in flight at a time; the result beat is held until taken.
// Depends on fbt_pkg and fbt_cell.
module free_block_table_fit_core #(
   parameter int POOL_DEPTH = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // block_address, block_size, request_size
   input  logic [1:0]   req_tuser,   // cmd
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,   // found_address, found_size
   output logic [1:0]   rsp_tuser,   // status
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_data
);

   localparam int CNT_W = $clog2(POOL_DEPTH + 1);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_APPLY = 2'd2;
   localparam logic [1:0] S_OUT = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in, count_ff, count_in;
   logic [1:0]       cmd_ff;
   logic [31:0]      addr_ff, bsize_ff, req_ff, ceil_ff;
   logic [16:0]      margin_ff;
   logic [1:0]       status_ff, status_in;
   logic [31:0]      faddr_ff, faddr_in, fsize_ff, fsize_in;
   logic             is_insert, full;

   fbt_pkg::ctrl_type  ctrl;
   fbt_pkg::token_type tok0, tok_last;
   fbt_pkg::token_type tok [POOL_DEPTH];
   logic               cv [POOL_DEPTH];
   logic [31:0]        ca [POOL_DEPTH];
   logic [31:0]        cs [POOL_DEPTH];

   assign is_insert = (cmd_ff == fbt_pkg::CMD_INS_SIZE) || (cmd_ff == fbt_pkg::CMD_INS_ADDR);
   assign full = (count_ff == CNT_W'(POOL_DEPTH));
   assign tok_last = tok[POOL_DEPTH-1];

   always_comb begin
      tok0 = '0;
      tok0.best = (cmd_ff == fbt_pkg::CMD_SMALL_FIT) ? ceil_ff : 32'd0;
   end

   always_comb begin
      ctrl.cmd = cmd_ff;
      ctrl.addr = addr_ff;
      ctrl.bsize = bsize_ff;
      ctrl.req = req_ff;
      ctrl.margin = margin_ff;
      ctrl.do_insert = (state_ff == S_APPLY) && is_insert && !full;
      ctrl.do_remove = (state_ff == S_APPLY) && !is_insert && tok_last.have;
      if (is_insert && !tok_last.have) begin
         ctrl.pos = fbt_pkg::POS_W'(count_ff);
      end else begin
         ctrl.pos = tok_last.pos;
      end
   end

   for (genvar g = 0; g < POOL_DEPTH; g++) begin : g_cell
      fbt_cell #(.IDX(g)) u_cell (
         .clock(clock),
         .reset(reset),
         .ctrl(ctrl),
         .tok_prev(g == 0 ? tok0 : tok[(g == 0) ? 0 : g-1]),
         .tok_out(tok[g]),
         .left_valid(g == 0 ? 1'b0 : cv[(g == 0) ? 0 : g-1]),
         .left_addr(ca[(g == 0) ? 0 : g-1]),
         .left_size(cs[(g == 0) ? 0 : g-1]),
         .right_valid(g == POOL_DEPTH-1 ? 1'b0 : cv[(g == POOL_DEPTH-1) ? g : g+1]),
         .right_addr(ca[(g == POOL_DEPTH-1) ? g : g+1]),
         .right_size(cs[(g == POOL_DEPTH-1) ? g : g+1]),
         .valid(cv[g]),
         .addr(ca[g]),
         .size(cs[g])
      );
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      count_in = count_ff;
      status_in = status_ff;
      faddr_in = faddr_ff;
      fsize_in = fsize_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_SCAN;
               cnt_in = '0;
            end
         end
         S_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(POOL_DEPTH)) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            state_in = S_OUT;
            faddr_in = 32'd0;
            fsize_in = 32'd0;
            if (is_insert) begin
               if (full) begin
                  status_in = fbt_pkg::ST_FULL;
               end else begin
                  status_in = fbt_pkg::ST_OK;
                  count_in = count_ff + 1'b1;
               end
            end else if (tok_last.have) begin
               status_in = fbt_pkg::ST_OK;
               faddr_in = tok_last.addr;
               fsize_in = tok_last.size;
               count_in = count_ff - 1'b1;
            end else begin
               status_in = fbt_pkg::ST_MISS;
            end
         end
         default: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         count_ff <= '0;
         margin_ff <= 17'd256;
         ceil_ff <= 32'hFFFF_FFFF;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         count_ff <= count_in;
         if (csr_valid && csr_index == {1'b0, fbt_pkg::REG_MARGIN}) begin
            margin_ff <= csr_data[16:0];
         end
         if (csr_valid && csr_index == {1'b0, fbt_pkg::REG_CEILING}) begin
            ceil_ff <= csr_data;
         end
      end
      if (req_tvalid && req_tready) begin
         cmd_ff <= req_tuser;
         addr_ff <= req_tdata[31:0];
         bsize_ff <= req_tdata[63:32];
         req_ff <= req_tdata[95:64];
      end
      status_ff <= status_in;
      faddr_ff <= faddr_in;
      fsize_ff <= fsize_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata = {fsize_ff, faddr_ff};
   assign rsp_tuser = status_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(POOL_DEPTH))
      else $error("entry count beyond table depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPLY && is_insert && !full) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not grow the table");

   a_hit_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPLY && !is_insert && tok_last.have) |=>
      count_ff == $past(count_ff) - 1'b1)
      else $error("hit did not shrink the table");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != fbt_pkg::ST_OK) |-> rsp_tdata == 64'd0)
      else $error("miss or full result carries data");

endmodule

// File: bench/free_block_table_fit_core_test.sv
// Self-checking bench for free_block_table_fit_core: directed table, fill-up, random items.
// Depends on fbt_pkg and the core; a local predictor of the free table computes each result.
`timescale 1ns / 100ps

module free_block_table_fit_core_test;

   localparam int DEPTH = 64;
   localparam int RUN_ITEMS = 1600;

   typedef struct {
      logic [1:0]  cmd;
      logic [31:0] addr;
      logic [31:0] bsize;
      logic [31:0] req;
   } fit_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] found_addr;
      logic [31:0] found_size;
   } fit_result_type;

   typedef struct {
      fit_item_type   item;
      bit             typed;
      fit_result_type want;
   } table_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [95:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [31:0] csr_data;

   free_block_table_fit_core #(.POOL_DEPTH(DEPTH)) dut (.*);

   // Predictor copy of the free table and registers.
   logic [31:0] pool_addr [DEPTH];
   logic [31:0] pool_size [DEPTH];
   int          pool_count;
   logic [16:0] margin_reg;
   logic [31:0] ceiling_reg;

   fit_result_type pending_results [$];
   fit_result_type typed_results [$];
   bit             typed_flags [$];
   int             mismatch_count;
   int             unexpected_count;
   bit             sender_quiet;
   bit             receiver_quiet;
   bit             long_hold;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #80_000_000;
      $display("[free_block_table_fit_core] ERROR");
      $finish;
   end

   function automatic fit_result_type take_entry(int pos);
      fit_result_type r;
      r.status = fbt_pkg::ST_OK;
      r.found_addr = pool_addr[pos];
      r.found_size = pool_size[pos];
      for (int i = pos; i + 1 < pool_count; i++) begin
         pool_addr[i] = pool_addr[i + 1];
         pool_size[i] = pool_size[i + 1];
      end
      pool_count--;
      return r;
   endfunction

   function automatic fit_result_type predict_fit(fit_item_type it);
      fit_result_type r;
      int             pos;
      bit             have;
      logic [31:0]    best;
      logic [31:0]    s;
      r.status = fbt_pkg::ST_OK;
      r.found_addr = '0;
      r.found_size = '0;
      if (it.cmd == fbt_pkg::CMD_INS_SIZE || it.cmd == fbt_pkg::CMD_INS_ADDR) begin
         if (pool_count >= DEPTH) begin
            r.status = fbt_pkg::ST_FULL;
            return r;
         end
         pos = pool_count;
         for (int i = 0; i < pool_count; i++) begin
            if (it.cmd == fbt_pkg::CMD_INS_SIZE ? (pool_size[i] >= it.bsize)
                                                : (pool_addr[i] > it.addr)) begin
               pos = i;
               break;
            end
         end
         for (int i = pool_count; i > pos; i--) begin
            pool_addr[i] = pool_addr[i - 1];
            pool_size[i] = pool_size[i - 1];
         end
         pool_addr[pos] = it.addr;
         pool_size[pos] = it.bsize;
         pool_count++;
         return r;
      end
      have = 1'b0;
      pos = 0;
      if (it.cmd == fbt_pkg::CMD_BEST_FIT) begin
         best = '0;
         for (int i = 0; i < pool_count; i++) begin
            s = pool_size[i];
            if (s >= it.req) begin
               if ({15'd0, s - it.req} < {32'd0, margin_reg}) return take_entry(i);
               if (s > best) begin
                  best = s;
                  pos = i;
                  have = 1'b1;
               end
            end
         end
      end else begin
         best = ceiling_reg;
         for (int i = 0; i < pool_count; i++) begin
            s = pool_size[i];
            if (s >= it.req && s < best) begin
               best = s;
               pos = i;
               have = 1'b1;
               if (s == it.req) break;
            end
         end
      end
      if (have) return take_entry(pos);
      r.status = fbt_pkg::ST_MISS;
      return r;
   endfunction

   task automatic random_gap();
      int n;
      if (!sender_quiet && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 7);
         repeat (n) @(posedge clock);
      end
   endtask

   // Waits past the accepted beat so the next drive lands in a later step.
   task automatic send_item(fit_item_type it, bit typed, fit_result_type want);
      req_tvalid <= 1'b1;
      req_tuser <= it.cmd;
      req_tdata <= {it.req, it.bsize, it.addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(predict_fit(it));
      typed_flags.push_back(typed);
      typed_results.push_back(want);
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (pending_results.size() != 0) @(posedge clock);
      // A result beat leaves the block before its next command can start.
      repeat (DEPTH + 8) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] index, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (index == fbt_pkg::REG_MARGIN) margin_reg = value[16:0];
      else if (index == fbt_pkg::REG_CEILING) ceiling_reg = value;
      @(posedge clock);
   endtask

   function automatic logic [31:0] rand_size();
      unique case ($urandom_range(0, 5))
         0: return $urandom_range(1, 16);
         1: return $urandom();
         2: return 32'hFFFF_FFFF - $urandom_range(0, 8);
         default: return $urandom_range(1, 4096);
      endcase
   endfunction

   // Result checker.
   always @(posedge clock) begin
      fit_result_type exp_r;
      fit_result_type typed_r;
      bit             typed;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            unexpected_count++;
            $display("unexpected result beat: status %0d", rsp_tuser);
         end else begin
            exp_r = pending_results.pop_front();
            typed = typed_flags.pop_front();
            typed_r = typed_results.pop_front();
            if (typed && typed_r != exp_r) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("table row disagrees with predictor: %0d/%h/%h vs %0d/%h/%h",
                           typed_r.status, typed_r.found_addr, typed_r.found_size,
                           exp_r.status, exp_r.found_addr, exp_r.found_size);
            end
            if (rsp_tuser != exp_r.status || rsp_tdata[31:0] != exp_r.found_addr
                || rsp_tdata[63:32] != exp_r.found_size) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result mismatch: expected %0d/%h/%h got %0d/%h/%h",
                           exp_r.status, exp_r.found_addr, exp_r.found_size,
                           rsp_tuser, rsp_tdata[31:0], rsp_tdata[63:32]);
            end
         end
      end
   end

   // Receiver side stalls, including one long hold that backs the block up.
   initial begin
      int n;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_tready <= 1'b0;
            n = 0;
            while (n < 600) begin
               @(posedge clock);
               n++;
            end
            long_hold = 1'b0;
            rsp_tready <= 1'b1;
         end else if (!receiver_quiet && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 7);
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      table_row_type  rows [$];
      table_row_type  row;
      fit_result_type ok_r;
      fit_result_type miss_r;
      fit_result_type full_r;
      fit_result_type none_r;
      fit_item_type   it;
      int             sent;
      int             phase;

      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = fbt_pkg::CMD_INS_SIZE;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      sender_quiet = 1'b0;
      receiver_quiet = 1'b0;
      long_hold = 1'b0;
      mismatch_count = 0;
      unexpected_count = 0;
      pool_count = 0;
      margin_reg = 17'd256;
      ceiling_reg = 32'hFFFF_FFFF;
      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      ok_r = '{fbt_pkg::ST_OK, 32'd0, 32'd0};
      miss_r = '{fbt_pkg::ST_MISS, 32'd0, 32'd0};
      none_r = ok_r;

      // Directed rows: searches on the empty table, extremes, both inserts.
      rows.push_back('{'{fbt_pkg::CMD_BEST_FIT, 0, 0, 32'd1}, 1, miss_r});
      rows.push_back('{'{fbt_pkg::CMD_SMALL_FIT, 0, 0, 32'hFFFF_FFFF}, 1, miss_r});
      rows.push_back('{'{fbt_pkg::CMD_INS_SIZE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0}, 1, ok_r});
      rows.push_back('{'{fbt_pkg::CMD_INS_SIZE, 32'd0, 32'd0, 0}, 1, ok_r});
      rows.push_back('{'{fbt_pkg::CMD_INS_ADDR, 32'h1000, 32'd300, 0}, 1, ok_r});
      rows.push_back('{'{fbt_pkg::CMD_INS_ADDR, 32'h0800, 32'd300, 0}, 1, ok_r});
      rows.push_back('{'{fbt_pkg::CMD_INS_SIZE, 32'h2000, 32'd100, 0}, 1, ok_r});
      // Exact fit stops the smallest-fit scan.
      rows.push_back('{'{fbt_pkg::CMD_SMALL_FIT, 0, 0, 32'd100}, 1,
                       '{fbt_pkg::ST_OK, 32'h2000, 32'd100}});
      // Request of zero fits the zero-size block under close fit.
      rows.push_back('{'{fbt_pkg::CMD_BEST_FIT, 0, 0, 32'd0}, 1,
                       '{fbt_pkg::ST_OK, 32'd0, 32'd0}});
      rows.push_back('{'{fbt_pkg::CMD_BEST_FIT, 0, 0, 32'd1000}, 0, none_r});
      rows.push_back('{'{fbt_pkg::CMD_SMALL_FIT, 0, 0, 32'd1}, 0, none_r});
      rows.push_back('{'{fbt_pkg::CMD_BEST_FIT, 0, 0, 32'hFFFF_FFFF}, 0, none_r});
      rows.push_back('{'{fbt_pkg::CMD_BEST_FIT, 0, 0, 32'hFFFF_FFFF}, 1, miss_r});
      foreach (rows[i]) begin
         send_item(rows[i].item, rows[i].typed, rows[i].want);
         random_gap();
      end
      drain();

      // Fill to capacity, then inserts are dropped.
      full_r = '{fbt_pkg::ST_FULL, 32'd0, 32'd0};
      while (pool_count < DEPTH) begin
         it = '{fbt_pkg::CMD_INS_ADDR, $urandom(), rand_size(), 0};
         send_item(it, 0, none_r);
         random_gap();
      end
      send_item('{fbt_pkg::CMD_INS_SIZE, 32'h55, 32'd7, 0}, 1, full_r);
      send_item('{fbt_pkg::CMD_INS_ADDR, 32'h55, 32'd7, 0}, 1, full_r);
      drain();

      // Random phases with register settings including extremes.
      sent = 0;
      phase = 0;
      while (sent < RUN_ITEMS) begin
         unique case (phase % 5)
            0: begin
               write_reg(fbt_pkg::REG_MARGIN, 32'd1);
               write_reg(fbt_pkg::REG_CEILING, 32'hFFFF_FFFF);
            end
            1: begin
               write_reg(fbt_pkg::REG_MARGIN, 32'h10000);
               write_reg(fbt_pkg::REG_CEILING, 32'd1);
            end
            2: begin
               write_reg(fbt_pkg::REG_MARGIN, $urandom());
               write_reg(fbt_pkg::REG_CEILING, $urandom());
            end
            3: begin
               write_reg(fbt_pkg::REG_MARGIN, 32'd256);
               write_reg(fbt_pkg::REG_CEILING, 32'd2000);
            end
            default: begin
               write_reg(fbt_pkg::REG_MARGIN, $urandom_range(1, 65536));
               write_reg(fbt_pkg::REG_CEILING, $urandom_range(1, 5000));
            end
         endcase
         if (phase == 2) long_hold = 1'b1;
         if (sent >= RUN_ITEMS - 250) begin
            sender_quiet = 1'b1;
            receiver_quiet = 1'b1;
         end
         repeat (200) begin
            it.cmd = $urandom_range(0, 3);
            it.addr = $urandom();
            it.bsize = rand_size();
            it.req = rand_size();
            if ($urandom_range(0, 7) == 0) it.req = 32'd0;
            if ($urandom_range(0, 9) == 0) it.bsize = 32'd0;
            if (pool_count > 0 && $urandom_range(0, 3) == 0)
               it.req = pool_size[$urandom_range(0, pool_count - 1)];
            send_item(it, 0, none_r);
            sent++;
            random_gap();
         end
         drain();
         phase++;
      end

      if (mismatch_count == 0 && unexpected_count == 0 && pending_results.size() == 0)
         $display("[free_block_table_fit_core] OK");
      else
         $display("[free_block_table_fit_core] ERROR");
      $finish;
   end

endmodule
